// ===== rtl/core/gsa_pkg.sv =====
// ---------------------------------------------------------------------------
// Generational slot allocator package
// Shared widths, codes and payload types of the slot allocator.
// ---------------------------------------------------------------------------
package gsa_pkg;

   // default sizing of the pool
   localparam int GSA_MAX_SLOTS  = 256;
   localparam int GSA_EPOCH_BITS = 32;

   // fixed field widths
   localparam int OPCODE_W       = 2;
   localparam int SLOT_INDEX_W   = 16;
   localparam int HANDLE_EPOCH_W = 32;
   localparam int STATUS_W       = 2;
   localparam int GRANT_SLOT_W   = 8;
   localparam int GRANT_EPOCH_W  = 32;
   localparam int FREE_COUNT_W   = 9;

   // configuration register file
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CAP_W       = 9;
   localparam int CAP_RESET   = 256;
   localparam logic CSR_IDX_POOL_CAPACITY = 1'b0;

   // epoch a slot carries after pool initialization
   localparam int EPOCH_INIT = 1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CHECK   = 2'd2
   } gsa_opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_INVALID  = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } gsa_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC
   } gsa_state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic [SLOT_INDEX_W-1:0]   slot_index;
      logic [HANDLE_EPOCH_W-1:0] handle_epoch;
   } gsa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [GRANT_SLOT_W-1:0]  granted_slot;
      logic [GRANT_EPOCH_W-1:0] granted_epoch;
      logic                     handle_valid;
      logic [FREE_COUNT_W-1:0]  free_count;
   } gsa_rsp_type;

   // sequencing strobes from the control FSM to the pool datapath
   typedef struct packed {
      logic issue;
      logic lookup;
      logic commit;
      logic init;
   } gsa_ctl_type;

endpackage

// ===== rtl/core/gsa_chan_if.sv =====
// ---------------------------------------------------------------------------
// Slot allocator channel
// Valid/ready channel carrying one payload struct per transfer.
// ---------------------------------------------------------------------------
interface gsa_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/generational_slot_allocator_top.sv =====
// Generational slot allocator: hands out handles (slot, epoch) from a pool of
// up to MAX_SLOTS slots and checks or retires them. A request passes lookup
// and execute: the free stack memory is read at the transfer, the slot memory
// is read in the next cycle (at the popped slot for acquire, at the handle's
// slot otherwise), and execute, which waits while an untaken result fills the
// result register, resolves the request, writes the slot memory (and on
// release the free stack) back and loads the result register. The result
// register lets the next request transfer while a result still waits on
// rsp_ch. After reset and after every write of pool_capacity an initialization
// sweep rewrites both memories; req_ch.ready stays low during the sweep, CSR writes are taken as always.
// ---------------------------------------------------------------------------
// Generational slot allocator top level
// Request/result channels, the capacity CSR, the request sequencer and the
// result register around the pool datapath.
// ---------------------------------------------------------------------------
module generational_slot_allocator_top
   import gsa_pkg::*;
#(
   parameter int MAX_SLOTS  = GSA_MAX_SLOTS,
   parameter int EPOCH_BITS = GSA_EPOCH_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   gsa_chan_if.sink              req_ch,
   gsa_chan_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam logic [CNT_W-1:0] CAP_RESET_SAT =
      (CAP_RESET > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(CAP_RESET);

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic             cap_write;

   gsa_state_type state_ff, state_in;
   gsa_ctl_type   ctl;
   logic          pool_busy;
   gsa_rsp_type   pool_rsp;

   logic        rsp_valid_ff, rsp_valid_in;
   gsa_rsp_type rsp_data_ff;
   logic        out_free;

   // capacity register, saturated to the pool size
   assign csr_pready = 1'b1;
   assign cap_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CSR_IDX_POOL_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (cap_write) begin
         if (32'(csr_pwdata[CAP_W-1:0]) > 32'(MAX_SLOTS)) begin
            cap_in = CNT_W'(MAX_SLOTS);
         end else begin
            cap_in = CNT_W'(csr_pwdata[CAP_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET_SAT;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_POOL_CAPACITY) ? CSR_DATA_W'(cap_ff) : '0;

   // request sequencer
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      ctl.init     = cap_write;
      req_ch.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = !pool_busy;
            if (req_ch.valid && !pool_busy) begin
               ctl.issue = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ctl.lookup = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   gsa_pool #(
      .MAX_SLOTS  (MAX_SLOTS),
      .EPOCH_BITS (EPOCH_BITS)
   ) u_pool (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .req   (req_ch.data),
      .cap   (cap_ff),
      .busy  (pool_busy),
      .rsp   (pool_rsp)
   );

   // result register: load on commit, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_data_ff <= pool_rsp;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // a transferred request walks through lookup and execute in order
   a_seq_order: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_LOOKUP) ##1 (state_ff == ST_EXEC))
      else $error("request did not advance through lookup and execute");

   // an empty pool report always comes with a zero free count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.data.status == STATUS_EMPTY)) |-> (rsp_ch.data.free_count == '0))
      else $error("empty status with nonzero free count");

   // an invalid handle is never reported live
   a_invalid_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.data.status == STATUS_INVALID)) |-> !rsp_ch.data.handle_valid)
      else $error("invalid status with live handle");

   // no request enters while the initialization sweep runs
   a_sweep_block: assert property (@(posedge clock) disable iff (reset)
      (pool_busy && (state_ff == ST_IDLE)) |=> (state_ff == ST_IDLE))
      else $error("request taken during initialization sweep");

endmodule

// ===== rtl/core/gsa_pool.sv =====
// ---------------------------------------------------------------------------
// Slot allocator pool datapath
// Slot memory (occupancy and epoch) and free stack memory, the free count,
// the initialization sweep and the resolve/write-back of one request.
// ---------------------------------------------------------------------------
module gsa_pool
   import gsa_pkg::*;
#(
   parameter int MAX_SLOTS  = GSA_MAX_SLOTS,
   parameter int EPOCH_BITS = GSA_EPOCH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gsa_ctl_type                         ctl,
   input  gsa_req_type                         req,
   input  logic [$clog2(MAX_SLOTS + 1)-1:0]    cap,
   output logic                                busy,
   output gsa_rsp_type                         rsp
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int EW     = (EPOCH_BITS > HANDLE_EPOCH_W) ? EPOCH_BITS : HANDLE_EPOCH_W;
   localparam int RNG_W  = SLOT_INDEX_W + 1;

   typedef struct packed {
      logic                  occupied;
      logic [EPOCH_BITS-1:0] epoch;
   } slot_entry_type;

   // memories
   slot_entry_type    slot_ram  [MAX_SLOTS];
   logic [SLOT_W-1:0] stack_ram [MAX_SLOTS];

   // request and read data
   logic [OPCODE_W-1:0]       op_ff;
   logic [SLOT_INDEX_W-1:0]   slot_ff;
   logic [HANDLE_EPOCH_W-1:0] hepoch_ff;
   logic [SLOT_W-1:0]         stack_rd_ff;
   slot_entry_type            slot_rd_ff;

   // pool state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              sweep_ff, sweep_in;
   logic [SLOT_W-1:0] sweep_idx_ff, sweep_idx_in;

   // memory ports
   logic              slot_we, stack_we;
   logic [SLOT_W-1:0] slot_wa, slot_ra, stack_wa, stack_ra;
   slot_entry_type    slot_wd;
   logic [SLOT_W-1:0] stack_wd;

   // resolve terms
   logic in_range, live, at_max, pool_empty;

   assign busy = sweep_ff;

   // latch the request at transfer
   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         op_ff     <= req.opcode;
         slot_ff   <= req.slot_index;
         hepoch_ff <= req.handle_epoch;
      end
   end

   // sweep control and free count
   always_comb begin
      sweep_in     = sweep_ff;
      sweep_idx_in = sweep_idx_ff;
      count_in     = count_ff;
      if (ctl.init) begin
         sweep_in     = 1'b1;
         sweep_idx_in = '0;
      end else if (sweep_ff) begin
         sweep_idx_in = sweep_idx_ff + SLOT_W'(1);
         if (sweep_idx_ff == SLOT_W'(MAX_SLOTS - 1)) begin
            sweep_in = 1'b0;
            count_in = cap;
         end
      end else if (ctl.commit) begin
         case (op_ff)
            OP_ACQUIRE: begin
               if (!pool_empty) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_RELEASE: begin
               if (live && !at_max && (count_ff < CNT_W'(MAX_SLOTS))) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_idx_ff <= '0;
         count_ff     <= '0;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_idx_ff <= sweep_idx_in;
         count_ff     <= count_in;
      end
   end

   // resolve the request from the read data
   always_comb begin
      pool_empty = (count_ff == '0);
      in_range   = (RNG_W'(slot_ff) < RNG_W'(cap));
      live       = in_range && slot_rd_ff.occupied
                   && (EW'(slot_rd_ff.epoch) == EW'(hepoch_ff));
      at_max     = &slot_rd_ff.epoch;

      rsp            = '0;
      rsp.status     = STATUS_OK;
      rsp.free_count = FREE_COUNT_W'(count_in);
      case (op_ff)
         OP_ACQUIRE: begin
            if (pool_empty) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.granted_slot  = GRANT_SLOT_W'(stack_rd_ff);
               rsp.granted_epoch = GRANT_EPOCH_W'(slot_rd_ff.epoch);
            end
         end
         OP_RELEASE: begin
            rsp.handle_valid = live;
            if (!live) begin
               rsp.status = STATUS_INVALID;
            end else if (at_max) begin
               rsp.status = STATUS_OVERFLOW;
            end
         end
         OP_CHECK: begin
            rsp.handle_valid = live;
            rsp.status       = live ? STATUS_OK : STATUS_INVALID;
         end
         default: begin
            rsp.status = STATUS_OK;
         end
      endcase
   end

   // memory port selection: sweep, or write back of the committed request
   always_comb begin
      stack_ra = SLOT_W'(count_ff - CNT_W'(1));
      slot_ra  = (op_ff == OP_ACQUIRE) ? stack_rd_ff : slot_ff[SLOT_W-1:0];

      slot_we  = 1'b0;
      slot_wa  = sweep_idx_ff;
      slot_wd  = '0;
      stack_we = 1'b0;
      stack_wa = sweep_idx_ff;
      stack_wd = SLOT_W'(cap - CNT_W'(sweep_idx_ff) - CNT_W'(1));

      if (sweep_ff) begin
         slot_we          = 1'b1;
         slot_wd.occupied = 1'b0;
         slot_wd.epoch    = EPOCH_BITS'(EPOCH_INIT);
         stack_we         = 1'b1;
      end else if (ctl.commit) begin
         case (op_ff)
            OP_ACQUIRE: begin
               slot_we          = !pool_empty;
               slot_wa          = stack_rd_ff;
               slot_wd.occupied = 1'b1;
               slot_wd.epoch    = slot_rd_ff.epoch;
            end
            OP_RELEASE: begin
               slot_we          = live && !at_max;
               slot_wa          = slot_ff[SLOT_W-1:0];
               slot_wd.occupied = 1'b0;
               slot_wd.epoch    = slot_rd_ff.epoch + EPOCH_BITS'(1);
               stack_we         = live && !at_max && (count_ff < CNT_W'(MAX_SLOTS));
               stack_wa         = SLOT_W'(count_ff);
               stack_wd         = slot_ff[SLOT_W-1:0];
            end
            default: begin
               slot_we = 1'b0;
            end
         endcase
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_ram[slot_wa] <= slot_wd;
      end
      if (ctl.lookup) begin
         slot_rd_ff <= slot_ram[slot_ra];
      end
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ram[stack_wa] <= stack_wd;
      end
      if (ctl.issue) begin
         stack_rd_ff <= stack_ram[stack_ra];
      end
   end

endmodule
